// ===== hw/rtl/dcz_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcz_pkg: shared types and constants of the depth correspondence z-buffer
// Holds the command codes, register indexes, arithmetic widths and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package dcz_pkg;

    localparam int DEF_MAX_WIDTH  = 640;
    localparam int DEF_MAX_HEIGHT = 480;

    // Width of frame dimensions and quotients; covers the largest frame side.
    localparam int DIM_W   = 12;
    localparam int QW      = 12;
    localparam int COEF_N  = 12;
    localparam int ZW      = 64;
    localparam int NW      = 66;
    localparam int MAP_W   = 20;
    localparam int CNT_W   = 19;
    localparam logic [CNT_W-1:0] COUNT_MAX = 19'h7FFFF;

    localparam logic [2:0] CMD_LOAD_COEF = 3'd0;
    localparam logic [2:0] CMD_LOAD_REF  = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_PROCESS   = 3'd3;
    localparam logic [2:0] CMD_READ      = 3'd4;

    localparam logic [1:0] REG_DIFF   = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [15:0] DIFF_RESET   = 16'd70;
    localparam logic [9:0]  WIDTH_RESET  = 10'd640;
    localparam logic [8:0]  HEIGHT_RESET = 9'd480;

    typedef struct packed {
        logic cap;
        logic coef_wr;
        logic ref_wr;
        logic clr_start;
        logic clr_step;
        logic st_mul;
        logic st_sum;
        logic st_z;
        logic div_start;
        logic div_v;
        logic cell_rd;
        logic fin_plain;
        logic commit;
        logic fin_read;
    } ctl_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       pre_ok;
        logic       z_ok;
        logic       div_done;
        logic       bnd_ok;
        logic       clr_last;
    } ctl_sts_t;

endpackage

// ===== hw/rtl/depth_correspondence_zbuffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_correspondence_zbuffer: projective correspondence search with z-buffer
// Loads coefficients and a reference depth frame, reprojects current pixels
// into a correspondence map and reads map cells back.
// ----------------------------------------------------------------------------
// Usage. A command beat is taken at a rising edge with start high and busy
// low; its fields are cmd, pix_x, pix_y, depth_mm, textured, coef_index and
// coef_value. Every command returns exactly one result beat: done is high for
// one cycle with accepted, match_valid, match_u, match_v and match_count.
// The receiver cannot stall; the result is shown once and must be taken.
// Loads and ignored commands finish through the execute state and the result
// register; reads add the cell read state. A processed pixel that passes every
// check runs the multiply, sum, depth, depth check, divide, bound and evaluate
// states; the bit-serial divider forms the column and the row quotients one bit
// per cycle, twelve bits each, one after the other. A pixel rejected early
// finishes at the execute, depth check or bound state. A clear command sweeps
// the map one cell per cycle. After reset the same sweep runs with busy high
// before the first command is taken. Configuration writes over the APB port
// belong between commands, while no beat is in flight.
// The APB registers are max_depth_diff_mm at 0x0, frame_width at 0x4 and
// frame_height at 0x8; pready is always high.
// ----------------------------------------------------------------------------
module depth_correspondence_zbuffer #(
    parameter int MAX_WIDTH  = dcz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcz_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                cmd,
    input  logic [9:0]                pix_x,
    input  logic [8:0]                pix_y,
    input  logic [15:0]               depth_mm,
    input  logic                      textured,
    input  logic [3:0]                coef_index,
    input  logic signed [31:0]        coef_value,
    output logic                      done,
    output logic                      accepted,
    output logic                      match_valid,
    output logic [9:0]                match_u,
    output logic [8:0]                match_v,
    output logic [dcz_pkg::CNT_W-1:0] match_count,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [15:0] diff_reg;
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic        cfg_wr;

    dcz_pkg::ctl_cmd_t ctl;
    dcz_pkg::ctl_sts_t sts;

    // Configuration registers; the word index sits in paddr[3:2].
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg   <= dcz_pkg::DIFF_RESET;
            width_reg  <= dcz_pkg::WIDTH_RESET;
            height_reg <= dcz_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                dcz_pkg::REG_DIFF:   diff_reg   <= pwdata[15:0];
                dcz_pkg::REG_WIDTH:  width_reg  <= pwdata[9:0];
                dcz_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            dcz_pkg::REG_DIFF:   prdata = {16'h0000, diff_reg};
            dcz_pkg::REG_WIDTH:  prdata = {22'h0, width_reg};
            dcz_pkg::REG_HEIGHT: prdata = {23'h0, height_reg};
            default:             prdata = 32'h0;
        endcase
    end

    // The sequencer owns the handshake; the datapath holds all payload.
    dcz_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    dcz_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .sts               (sts),
        .cmd               (cmd),
        .pix_x             (pix_x),
        .pix_y             (pix_y),
        .depth_mm          (depth_mm),
        .textured          (textured),
        .coef_index        (coef_index),
        .coef_value        (coef_value),
        .max_depth_diff_mm (diff_reg),
        .frame_width       (width_reg),
        .frame_height      (height_reg),
        .done              (done),
        .accepted          (accepted),
        .match_valid       (match_valid),
        .match_u           (match_u),
        .match_v           (match_v),
        .match_count       (match_count)
    );

endmodule

// ===== hw/rtl/dcz_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcz_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dcz_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/dcz_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcz_div: bit-serial restoring divider
// Produces a short unsigned quotient one bit per cycle and flags a quotient
// that does not fit in the quotient width.
// ----------------------------------------------------------------------------
module dcz_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [dcz_pkg::NW-1:0] num,
    input  logic [dcz_pkg::NW-1:0] den,
    output logic                   done,
    output logic [dcz_pkg::QW-1:0] quot,
    output logic                   ovf
);

    localparam int NW = dcz_pkg::NW;
    localparam int QW = dcz_pkg::QW;
    localparam int SW = NW + QW;
    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] rem_reg;
    logic [SW-1:0] dsh_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic          ovf_reg;
    logic          ge;

    assign ge = ({{QW{1'b0}}, rem_reg} >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(QW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= SW'(den) << (QW - 1);
            q_reg   <= '0;
            ovf_reg <= ({{QW{1'b0}}, num} >= {den, {QW{1'b0}}});
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[NW-1:0];
            end
            q_reg   <= {q_reg[QW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== hw/rtl/dcz_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcz_ctrl: command sequencer
// Steps each command through the datapath and runs the map clearing passes.
// ----------------------------------------------------------------------------
module dcz_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output dcz_pkg::ctl_cmd_t ctl,
    input  dcz_pkg::ctl_sts_t sts
);

    localparam logic [3:0] S_CLR_RST = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_EXEC    = 4'd2;
    localparam logic [3:0] S_CLR     = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_SUM     = 4'd5;
    localparam logic [3:0] S_Z       = 4'd6;
    localparam logic [3:0] S_CHKZ    = 4'd7;
    localparam logic [3:0] S_DIVU    = 4'd8;
    localparam logic [3:0] S_DIVV    = 4'd9;
    localparam logic [3:0] S_BND     = 4'd10;
    localparam logic [3:0] S_EVAL    = 4'd11;
    localparam logic [3:0] S_RDC     = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLR_RST:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.cap    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                unique case (sts.op)
                    dcz_pkg::CMD_LOAD_COEF:
                    begin
                        ctl.coef_wr   = 1'b1;
                        ctl.fin_plain = 1'b1;
                    end
                    dcz_pkg::CMD_LOAD_REF:
                    begin
                        ctl.ref_wr    = 1'b1;
                        ctl.fin_plain = 1'b1;
                    end
                    dcz_pkg::CMD_CLEAR:
                    begin
                        ctl.clr_start = 1'b1;
                        state_next    = S_CLR;
                    end
                    dcz_pkg::CMD_PROCESS:
                    begin
                        if (sts.pre_ok)
                        begin
                            state_next = S_MUL;
                        end
                        else
                        begin
                            ctl.fin_plain = 1'b1;
                        end
                    end
                    dcz_pkg::CMD_READ:
                    begin
                        ctl.cell_rd = 1'b1;
                        state_next  = S_RDC;
                    end
                    default:
                    begin
                        ctl.fin_plain = 1'b1;
                    end
                endcase
            end
            S_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    ctl.fin_plain = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MUL:
            begin
                ctl.st_mul = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                ctl.st_sum = 1'b1;
                state_next = S_Z;
            end
            S_Z:
            begin
                ctl.st_z   = 1'b1;
                state_next = S_CHKZ;
            end
            S_CHKZ:
            begin
                if (sts.z_ok)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIVU;
                end
                else
                begin
                    ctl.fin_plain = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DIVU:
            begin
                if (sts.div_done)
                begin
                    ctl.div_start = 1'b1;
                    ctl.div_v     = 1'b1;
                    state_next    = S_DIVV;
                end
            end
            S_DIVV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_BND;
                end
            end
            S_BND:
            begin
                if (sts.bnd_ok)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    ctl.fin_plain = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_EVAL:
            begin
                ctl.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_RDC:
            begin
                ctl.fin_read = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hw/rtl/dcz_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcz_datapath: reprojection arithmetic, frame memories and result registers
// Computes the reprojected position and depth of a pixel, keeps the
// reference frame, the correspondence map and the winner depths.
// ----------------------------------------------------------------------------
module dcz_datapath #(
    parameter int MAX_WIDTH  = dcz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcz_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dcz_pkg::ctl_cmd_t         ctl,
    output dcz_pkg::ctl_sts_t         sts,
    input  logic [2:0]                cmd,
    input  logic [9:0]                pix_x,
    input  logic [8:0]                pix_y,
    input  logic [15:0]               depth_mm,
    input  logic                      textured,
    input  logic [3:0]                coef_index,
    input  logic signed [31:0]        coef_value,
    input  logic [15:0]               max_depth_diff_mm,
    input  logic [9:0]                frame_width,
    input  logic [8:0]                frame_height,
    output logic                      done,
    output logic                      accepted,
    output logic                      match_valid,
    output logic [9:0]                match_u,
    output logic [8:0]                match_v,
    output logic [dcz_pkg::CNT_W-1:0] match_count
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int DIM_W = dcz_pkg::DIM_W;
    localparam int QW    = dcz_pkg::QW;
    localparam int NW    = dcz_pkg::NW;
    localparam int ZW    = dcz_pkg::ZW;
    localparam int MAP_W = dcz_pkg::MAP_W;

    logic [2:0]         cmd_reg;
    logic [9:0]         x_reg;
    logic [8:0]         y_reg;
    logic [15:0]        d_reg;
    logic               tex_reg;
    logic [3:0]         ci_reg;
    logic signed [31:0] cv_reg;

    logic signed [31:0] coef_reg [dcz_pkg::COEF_N];
    logic signed [42:0] px_reg [3];
    logic signed [42:0] py_reg [3];
    logic signed [44:0] s_reg [3];
    logic signed [ZW-1:0] r_reg [3];

    logic          vsel_reg;
    logic [QW-1:0] u_reg;
    logic [QW-1:0] v_reg;
    logic          uo_reg;
    logic          vo_reg;
    logic [AW-1:0] clr_reg;

    logic                      done_reg;
    logic                      acc_reg;
    logic                      mv_reg;
    logic [9:0]                mu_reg;
    logic [8:0]                mvv_reg;
    logic [dcz_pkg::CNT_W-1:0] cnt_reg;

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic             in_frame;
    logic [AW-1:0]    idx_in;
    logic [AW-1:0]    idx_pix;
    logic signed [ZW-1:0] z_val;
    logic signed [NW-1:0] num_u;
    logic signed [NW-1:0] num_v;
    logic [NW-1:0]    div_num;
    logic [NW-1:0]    div_den;
    logic             div_done;
    logic [QW-1:0]    div_q;
    logic             div_ovf;

    logic [15:0]      ref_rd;
    logic [MAP_W-1:0] map_rd;
    logic [31:0]      win_rd;
    logic             map_we;
    logic [AW-1:0]    map_waddr;
    logic [MAP_W-1:0] map_wdata;
    logic [AW-1:0]    map_raddr;

    logic signed [ZW-1:0] gap;
    logic [ZW-1:0]    gap_abs;
    logic [31:0]      zs;
    logic             eval_ok;
    logic             wr_hit;

    // Frame limits in use: the register value clipped to the memory size.
    assign eff_w = ({2'b0, frame_width} < DIM_W'(MAX_WIDTH)) ?
                   {2'b0, frame_width} : DIM_W'(MAX_WIDTH);
    assign eff_h = ({3'b0, frame_height} < DIM_W'(MAX_HEIGHT)) ?
                   {3'b0, frame_height} : DIM_W'(MAX_HEIGHT);
    assign in_frame = ({2'b0, x_reg} < eff_w) && ({3'b0, y_reg} < eff_h);
    assign idx_in  = AW'(y_reg * MAX_WIDTH) + AW'(x_reg);
    assign idx_pix = AW'(v_reg * MAX_WIDTH) + AW'(u_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.cap)
        begin
            cmd_reg <= cmd;
            x_reg   <= pix_x;
            y_reg   <= pix_y;
            d_reg   <= depth_mm;
            tex_reg <= textured;
            ci_reg  <= coef_index;
            cv_reg  <= coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dcz_pkg::COEF_N; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (ctl.coef_wr && (ci_reg < 4'(dcz_pkg::COEF_N)))
        begin
            coef_reg[ci_reg] <= cv_reg;
        end
    end

    // Rows 0, 1, 2 give nu, nv and z; each row is c_a*x + c_b*y + c_c,
    // scaled by depth, plus its translation term.
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        always_ff @(posedge clk)
        begin
            if (ctl.st_mul)
            begin
                px_reg[r] <= 43'(coef_reg[3*r]) * 43'($signed({1'b0, x_reg}));
                py_reg[r] <= 43'(coef_reg[3*r+1]) * 43'($signed({1'b0, y_reg}));
            end
            if (ctl.st_sum)
            begin
                s_reg[r] <= 45'(px_reg[r]) + 45'(py_reg[r]) + 45'(coef_reg[3*r+2]);
            end
            if (ctl.st_z)
            begin
                r_reg[r] <= ZW'($signed({1'b0, d_reg})) * ZW'(s_reg[r]) +
                            ZW'(coef_reg[9+r]);
            end
        end
    end

    assign z_val = r_reg[2];
    // Rounded quotient is floor((2n + z) / 2z).
    assign num_u = (NW'(r_reg[0]) <<< 1) + NW'(z_val);
    assign num_v = (NW'(r_reg[1]) <<< 1) + NW'(z_val);
    assign div_num = ctl.div_v ? num_v : num_u;
    assign div_den = NW'(z_val) <<< 1;

    dcz_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q),
        .ovf   (div_ovf)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            vsel_reg <= ctl.div_v;
        end
        if (div_done && !vsel_reg)
        begin
            u_reg  <= div_q;
            uo_reg <= div_ovf;
        end
        if (div_done && vsel_reg)
        begin
            v_reg  <= div_q;
            vo_reg <= div_ovf;
        end
    end

    // Memories.
    assign map_raddr = ctl.cell_rd ? idx_in : idx_pix;
    assign wr_hit    = ctl.commit && eval_ok;
    assign map_we    = ctl.clr_step || wr_hit;
    assign map_waddr = ctl.clr_step ? clr_reg : idx_pix;
    assign map_wdata = ctl.clr_step ? '0 : {1'b1, x_reg, y_reg};

    dcz_ram #(.W(16), .DEPTH(CELLS)) u_ref_ram (
        .clk   (clk),
        .we    (ctl.ref_wr && in_frame),
        .waddr (idx_in),
        .wdata (d_reg),
        .raddr (idx_pix),
        .rdata (ref_rd)
    );

    dcz_ram #(.W(MAP_W), .DEPTH(CELLS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rd)
    );

    dcz_ram #(.W(32), .DEPTH(CELLS)) u_win_ram (
        .clk   (clk),
        .we    (wr_hit),
        .waddr (idx_pix),
        .wdata (zs),
        .raddr (idx_pix),
        .rdata (win_rd)
    );

    // Depth test against the reference and the stored winner.
    assign gap     = z_val - $signed(ZW'({ref_rd, 16'h0000}));
    assign gap_abs = gap[ZW-1] ? ZW'(-gap) : ZW'(gap);
    assign zs      = (z_val[ZW-1:32] != '0) ? 32'hFFFF_FFFF : z_val[31:0];
    assign eval_ok = (ref_rd != 16'd0) &&
                     (gap_abs <= ZW'({max_depth_diff_mm, 16'h0000})) &&
                     (!map_rd[MAP_W-1] || (zs <= win_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            acc_reg  <= 1'b0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clr_start)
            begin
                clr_reg <= '0;
                cnt_reg <= '0;
            end
            else if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (wr_hit && !map_rd[MAP_W-1] && (cnt_reg < dcz_pkg::COUNT_MAX))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            done_reg <= ctl.fin_plain || ctl.commit || ctl.fin_read;
            acc_reg  <= ctl.commit && eval_ok;
            mv_reg   <= ctl.fin_read && in_frame && map_rd[MAP_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin_read && in_frame && map_rd[MAP_W-1])
        begin
            mu_reg  <= map_rd[18:9];
            mvv_reg <= map_rd[8:0];
        end
        else
        begin
            mu_reg  <= '0;
            mvv_reg <= '0;
        end
    end

    assign sts.op       = cmd_reg;
    assign sts.pre_ok   = in_frame && (d_reg != 16'd0) && tex_reg;
    assign sts.z_ok     = !z_val[ZW-1] && (z_val != '0) && !num_u[NW-1] && !num_v[NW-1];
    assign sts.div_done = div_done;
    assign sts.bnd_ok   = !uo_reg && !vo_reg && (u_reg < eff_w) && (v_reg < eff_h);
    assign sts.clr_last = (clr_reg == AW'(CELLS - 1));

    assign done        = done_reg;
    assign accepted    = acc_reg;
    assign match_valid = mv_reg;
    assign match_u     = mu_reg;
    assign match_v     = mvv_reg;
    assign match_count = cnt_reg;

endmodule
